// ===== hdl/tnsp_pkg.sv =====
// Shared widths, register indexes and sideband structs for the torus nearest-point core.
package tnsp_pkg;

   localparam int COORD_W    = 32;
   localparam int RAD_W      = 30;
   localparam int ROOT_W     = 32;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int MAG_W      = 31;
   localparam int NUM_W      = 62;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAJOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MINOR = 2'd1;

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   // carried beside the first square root
   typedef struct packed {
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qy;
      logic signed [COORD_W-1:0] qz;
   } sq1_side_type;

   // carried beside the projection divide
   typedef struct packed {
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qy;
      logic signed [COORD_W-1:0] qz;
      logic [ROOT_W-1:0]         m;
      logic                      sx;
      logic                      sy;
   } dv1_side_type;

   // carried beside the second square root
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qy;
      logic [ROOT_W-1:0]         m;
      logic [2:0]                esgn;
      logic [MAG_W-1:0]          ex;
      logic [MAG_W-1:0]          ey;
      logic [MAG_W-1:0]          ez;
   } sq2_side_type;

   // carried beside the tube divide
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic [2:0]                sgn;
   } dv2_side_type;

endpackage

// ===== hdl/tnsp_sqrt_cell.sv =====
// Pipelined integer square-root digit cell: one root bit per cycle while en is high.
module tnsp_sqrt_cell #(
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [ROOT_W+1:0]     in_rem,
   input  logic [ROOT_W-1:0]     in_root,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_vld,
   output logic [2*ROOT_W-1:0]   out_rad,
   output logic [ROOT_W+1:0]     out_rem,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int REM_W = ROOT_W + 2;

   logic                vld_ff;
   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [REM_W+1:0]    acc, trial, diff;
   logic                ge;

   // bring down the next two radicand bits, try root*4+1
   always_comb begin
      acc     = {in_rem, in_rad[2*ROOT_W-1 -: 2]};
      trial   = {2'b00, in_root, 2'b01};
      diff    = acc - trial;
      ge      = (acc >= trial);
      rem_in  = ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
      root_in = {in_root[ROOT_W-2:0], ge};
      rad_in  = {in_rad[2*ROOT_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rad  = rad_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_side = side_ff;

endmodule

// ===== hdl/tnsp_isqrt.sv =====
// Chain of square-root cells: floor(sqrt(v)) of a 2*ROOT_W bit value, one cell per root bit.
module tnsp_isqrt #(
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [2*ROOT_W-1:0] in_val,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_vld,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   logic [ROOT_W:0]                 vld;
   logic [ROOT_W:0][2*ROOT_W-1:0]   rad;
   logic [ROOT_W:0][ROOT_W+1:0]     rem;
   logic [ROOT_W:0][ROOT_W-1:0]     root;
   logic [ROOT_W:0][SIDE_W-1:0]     side;

   assign vld[0]  = in_vld;
   assign rad[0]  = in_val;
   assign rem[0]  = '0;
   assign root[0] = '0;
   assign side[0] = in_side;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_cell
      tnsp_sqrt_cell #(
         .ROOT_W (ROOT_W),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (vld[j]),
         .in_rad   (rad[j]),
         .in_rem   (rem[j]),
         .in_root  (root[j]),
         .in_side  (side[j]),
         .out_vld  (vld[j+1]),
         .out_rad  (rad[j+1]),
         .out_rem  (rem[j+1]),
         .out_root (root[j+1]),
         .out_side (side[j+1])
      );
   end

   assign out_vld  = vld[ROOT_W];
   assign out_root = root[ROOT_W];
   assign out_side = side[ROOT_W];

endmodule

// ===== hdl/tnsp_div_cell.sv =====
// Restoring-division cell: one quotient bit per lane per cycle when enabled; shared divisor.
module tnsp_div_cell #(
   parameter int LANES  = 2,
   parameter int NUM_W  = 62,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [DEN_W-1:0]             in_den,
   input  logic [LANES-1:0][NUM_W-1:0]  in_num,
   input  logic [LANES-1:0][DEN_W-1:0]  in_rem,
   input  logic [LANES-1:0][NUM_W-1:0]  in_quot,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_vld,
   output logic [DEN_W-1:0]             out_den,
   output logic [LANES-1:0][NUM_W-1:0]  out_num,
   output logic [LANES-1:0][DEN_W-1:0]  out_rem,
   output logic [LANES-1:0][NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0]            out_side
);

   logic                         vld_ff;
   logic [DEN_W-1:0]             den_ff;
   logic [LANES-1:0][NUM_W-1:0]  num_ff, num_in;
   logic [LANES-1:0][DEN_W-1:0]  rem_ff, rem_in;
   logic [LANES-1:0][NUM_W-1:0]  quot_ff, quot_in;
   logic [SIDE_W-1:0]            side_ff;
   logic [LANES-1:0][DEN_W:0]    trial, diff;
   logic [LANES-1:0]             ge;

   // shift in the next numerator bit and subtract the divisor where it fits
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l]   = {in_rem[l], in_num[l][NUM_W-1]};
         diff[l]    = trial[l] - {1'b0, in_den};
         ge[l]      = (trial[l] >= {1'b0, in_den});
         rem_in[l]  = ge[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
         quot_in[l] = {in_quot[l][NUM_W-2:0], ge[l]};
         num_in[l]  = {in_num[l][NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= in_den;
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_den  = den_ff;
   assign out_num  = num_ff;
   assign out_rem  = rem_ff;
   assign out_quot = quot_ff;
   assign out_side = side_ff;

endmodule

// ===== hdl/tnsp_div.sv =====
// Chain of division cells: LANES unsigned quotients over one divisor, one cell per quotient bit.
module tnsp_div #(
   parameter int LANES  = 2,
   parameter int NUM_W  = 62,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [DEN_W-1:0]             in_den,
   input  logic [LANES-1:0][NUM_W-1:0]  in_num,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_vld,
   output logic [LANES-1:0][NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0]            out_side
);

   logic [NUM_W:0]                          vld;
   logic [NUM_W:0][DEN_W-1:0]               den;
   logic [NUM_W:0][LANES-1:0][NUM_W-1:0]    num;
   logic [NUM_W:0][LANES-1:0][DEN_W-1:0]    rem;
   logic [NUM_W:0][LANES-1:0][NUM_W-1:0]    quot;
   logic [NUM_W:0][SIDE_W-1:0]              side;

   assign vld[0]  = in_vld;
   assign den[0]  = in_den;
   assign num[0]  = in_num;
   assign rem[0]  = '0;
   assign quot[0] = '0;
   assign side[0] = in_side;

   for (genvar j = 0; j < NUM_W; j++) begin : g_cell
      tnsp_div_cell #(
         .LANES  (LANES),
         .NUM_W  (NUM_W),
         .DEN_W  (DEN_W),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (vld[j]),
         .in_den   (den[j]),
         .in_num   (num[j]),
         .in_rem   (rem[j]),
         .in_quot  (quot[j]),
         .in_side  (side[j]),
         .out_vld  (vld[j+1]),
         .out_den  (den[j+1]),
         .out_num  (num[j+1]),
         .out_rem  (rem[j+1]),
         .out_quot (quot[j+1]),
         .out_side (side[j+1])
      );
   end

   assign out_vld  = vld[NUM_W];
   assign out_quot = quot[NUM_W];
   assign out_side = side[NUM_W];

endmodule

// ===== hdl/torus_nearest_surface_point_core.sv =====
// Top level: nearest point on a z-axis torus, fully pipelined sqrt/divide datapath.
// Takes one query transaction per clock while req_stall is low and returns one result
// transaction per query, in order. The datapath is made of the two chains of square-root
// cells (32 cells each, one root bit per cell) and the two chains of divider cells
// (62 cells each, one quotient bit per cell), plus thirteen registered stages (the input
// register included) and the output register. The pipeline keeps moving while a finished
// result waits, as long as its last stage is empty; req_stall rises only when the output
// register holds a stalled result and the last stage holds another one. Radii registers
// are written over the csr port (index 0 major radius, 1 minor radius, low 30 bits kept)
// and must only be changed while no transaction is in flight. Queries on the z axis use
// (R,0,0) as the circle point; queries on the centre circle use the outward radial
// direction.
module torus_nearest_surface_point_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tnsp_pkg::COORD_W-1:0] req_query_x,
   input  logic signed [tnsp_pkg::COORD_W-1:0] req_query_y,
   input  logic signed [tnsp_pkg::COORD_W-1:0] req_query_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tnsp_pkg::COORD_W-1:0] rsp_near_x,
   output logic signed [tnsp_pkg::COORD_W-1:0] rsp_near_y,
   output logic signed [tnsp_pkg::COORD_W-1:0] rsp_near_z,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tnsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tnsp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CW  = tnsp_pkg::COORD_W;
   localparam int RW  = tnsp_pkg::RAD_W;
   localparam int TW  = tnsp_pkg::ROOT_W;
   localparam int SW  = tnsp_pkg::SQ_W;
   localparam int MW  = tnsp_pkg::MAG_W;
   localparam int NW  = tnsp_pkg::NUM_W;
   localparam logic [RW-1:0] MAJOR_RESET = RW'(1) << FRAC_BITS;
   localparam logic [RW-1:0] MINOR_RESET = RW'(1) << (FRAC_BITS - 2);
   localparam int S1W = $bits(tnsp_pkg::sq1_side_type);
   localparam int D1W = $bits(tnsp_pkg::dv1_side_type);
   localparam int S2W = $bits(tnsp_pkg::sq2_side_type);
   localparam int D2W = $bits(tnsp_pkg::dv2_side_type);

   logic en;

   // radius registers
   logic [RW-1:0] major_ff, minor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= MAJOR_RESET;
         minor_ff <= MINOR_RESET;
      end else if (csr_valid) begin
         if (csr_index == tnsp_pkg::CSR_MAJOR) begin
            major_ff <= csr_data[RW-1:0];
         end
         if (csr_index == tnsp_pkg::CSR_MINOR) begin
            minor_ff <= csr_data[RW-1:0];
         end
      end
   end

   // ---------------- valid chain of the arithmetic stages ----------------
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff, g_vld_ff;
   logic h_vld_ff, i_vld_ff, j_vld_ff, k_vld_ff, m_vld_ff, l_vld_ff;
   logic s1_vld, d1_vld, s2_vld, d2_vld;

   // pipeline moves unless the last stage holds a result that cannot leave
   assign en        = !rsp_valid || !rsp_stall || !l_vld_ff;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
         k_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         l_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= s1_vld;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= d1_vld;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
         j_vld_ff <= i_vld_ff;
         k_vld_ff <= s2_vld;
         m_vld_ff <= k_vld_ff;
         l_vld_ff <= d2_vld;
      end
   end

   // ---------------- input register and squares of x, y ----------------
   logic signed [CW-1:0] a_qx_ff, a_qy_ff, a_qz_ff;
   logic signed [63:0]   sqx_full, sqy_full;
   logic [62:0]          b_sqx_ff, b_sqy_ff;
   logic signed [CW-1:0] b_qx_ff, b_qy_ff, b_qz_ff;
   logic [SW-1:0]        c_n2_ff;
   tnsp_pkg::sq1_side_type c_side_ff;

   assign sqx_full = a_qx_ff * a_qx_ff;
   assign sqy_full = a_qy_ff * a_qy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_qx_ff      <= req_query_x;
         a_qy_ff      <= req_query_y;
         a_qz_ff      <= req_query_z;
         b_sqx_ff     <= sqx_full[62:0];
         b_sqy_ff     <= sqy_full[62:0];
         b_qx_ff      <= a_qx_ff;
         b_qy_ff      <= a_qy_ff;
         b_qz_ff      <= a_qz_ff;
         c_n2_ff      <= {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
         c_side_ff.qx <= b_qx_ff;
         c_side_ff.qy <= b_qy_ff;
         c_side_ff.qz <= b_qz_ff;
      end
   end

   // ---------------- m = isqrt(x^2 + y^2) ----------------
   logic [TW-1:0]          s1_m;
   logic [S1W-1:0]         s1_side_bits;
   tnsp_pkg::sq1_side_type s1_side;

   tnsp_isqrt #(
      .ROOT_W (TW),
      .SIDE_W (S1W)
   ) u_sqrt_n (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (c_vld_ff),
      .in_val   (c_n2_ff),
      .in_side  (c_side_ff),
      .out_vld  (s1_vld),
      .out_root (s1_m),
      .out_side (s1_side_bits)
   );

   assign s1_side = tnsp_pkg::sq1_side_type'(s1_side_bits);

   // ---------------- |q| * R, then add rounding half of m ----------------
   logic [CW-1:0]          magx, magy;
   logic [NW-1:0]          d_prodx_ff, d_prody_ff;
   tnsp_pkg::dv1_side_type d_side_ff, e_side_ff;
   logic [1:0][NW-1:0]     e_num_ff;

   assign magx = s1_side.qx[CW-1] ? (~s1_side.qx + 1'b1) : s1_side.qx;
   assign magy = s1_side.qy[CW-1] ? (~s1_side.qy + 1'b1) : s1_side.qy;

   always_ff @(posedge clock) begin
      if (en) begin
         d_prodx_ff   <= magx * major_ff;
         d_prody_ff   <= magy * major_ff;
         d_side_ff.qx <= s1_side.qx;
         d_side_ff.qy <= s1_side.qy;
         d_side_ff.qz <= s1_side.qz;
         d_side_ff.m  <= s1_m;
         d_side_ff.sx <= s1_side.qx[CW-1];
         d_side_ff.sy <= s1_side.qy[CW-1];
         e_num_ff[0]  <= d_prodx_ff + NW'(d_side_ff.m >> 1);
         e_num_ff[1]  <= d_prody_ff + NW'(d_side_ff.m >> 1);
         e_side_ff    <= d_side_ff;
      end
   end

   // ---------------- circle point: round(|q|*R / m) ----------------
   logic [1:0][NW-1:0]     d1_quot;
   logic [D1W-1:0]         d1_side_bits;
   tnsp_pkg::dv1_side_type d1_side;

   tnsp_div #(
      .LANES  (2),
      .NUM_W  (NW),
      .DEN_W  (TW),
      .SIDE_W (D1W)
   ) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (e_vld_ff),
      .in_den   (e_side_ff.m),
      .in_num   (e_num_ff),
      .in_side  (e_side_ff),
      .out_vld  (d1_vld),
      .out_quot (d1_quot),
      .out_side (d1_side_bits)
   );

   assign d1_side = tnsp_pkg::dv1_side_type'(d1_side_bits);

   // ---------------- P, then D = Q - P ----------------
   logic signed [CW-1:0] px_sel, py_sel;
   logic signed [CW-1:0] f_px_ff, f_py_ff, f_qx_ff, f_qy_ff, f_qz_ff;
   logic [TW-1:0]        f_m_ff;
   logic signed [33:0]   g_dx_ff, g_dy_ff, g_dz_ff;
   logic signed [CW-1:0] g_px_ff, g_py_ff, g_qx_ff, g_qy_ff;
   logic [TW-1:0]        g_m_ff;

   // each |P| coordinate is at most R < 2^30, so the low bits hold the quotient exactly
   always_comb begin
      if (d1_side.m == '0) begin
         px_sel = signed'({{(CW-RW){1'b0}}, major_ff});
         py_sel = '0;
      end else begin
         px_sel = d1_side.sx ? -signed'(d1_quot[0][CW-1:0]) : signed'(d1_quot[0][CW-1:0]);
         py_sel = d1_side.sy ? -signed'(d1_quot[1][CW-1:0]) : signed'(d1_quot[1][CW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_px_ff <= px_sel;
         f_py_ff <= py_sel;
         f_qx_ff <= d1_side.qx;
         f_qy_ff <= d1_side.qy;
         f_qz_ff <= d1_side.qz;
         f_m_ff  <= d1_side.m;
         g_dx_ff <= 34'(f_qx_ff) - 34'(f_px_ff);
         g_dy_ff <= 34'(f_qy_ff) - 34'(f_py_ff);
         g_dz_ff <= 34'(f_qz_ff);
         g_px_ff <= f_px_ff;
         g_py_ff <= f_py_ff;
         g_qx_ff <= f_qx_ff;
         g_qy_ff <= f_qy_ff;
         g_m_ff  <= f_m_ff;
      end
   end

   // ---------------- scale D below 2^31, square, sum ----------------
   // |D| < 2^31 + 2^30, so at most one right shift is ever needed
   logic [33:0]          mdx, mdy, mdz;
   logic                 shift_one;
   logic [MW-1:0]        ex_sel, ey_sel, ez_sel;
   tnsp_pkg::sq2_side_type h_side_ff, i_side_ff, j_side_ff;
   logic [61:0]          i_sqx_ff, i_sqy_ff, i_sqz_ff;
   logic [SW-1:0]        j_sum_ff;

   always_comb begin
      mdx       = g_dx_ff[33] ? 34'(-g_dx_ff) : 34'(g_dx_ff);
      mdy       = g_dy_ff[33] ? 34'(-g_dy_ff) : 34'(g_dy_ff);
      mdz       = g_dz_ff[33] ? 34'(-g_dz_ff) : 34'(g_dz_ff);
      shift_one = |{mdx[33:31], mdy[33:31], mdz[33:31]};
      ex_sel    = shift_one ? mdx[MW:1] : mdx[MW-1:0];
      ey_sel    = shift_one ? mdy[MW:1] : mdy[MW-1:0];
      ez_sel    = shift_one ? mdz[MW:1] : mdz[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_side_ff.px   <= g_px_ff;
         h_side_ff.py   <= g_py_ff;
         h_side_ff.qx   <= g_qx_ff;
         h_side_ff.qy   <= g_qy_ff;
         h_side_ff.m    <= g_m_ff;
         h_side_ff.esgn <= {g_dz_ff[33], g_dy_ff[33], g_dx_ff[33]};
         h_side_ff.ex   <= ex_sel;
         h_side_ff.ey   <= ey_sel;
         h_side_ff.ez   <= ez_sel;
         i_sqx_ff       <= h_side_ff.ex * h_side_ff.ex;
         i_sqy_ff       <= h_side_ff.ey * h_side_ff.ey;
         i_sqz_ff       <= h_side_ff.ez * h_side_ff.ez;
         i_side_ff      <= h_side_ff;
         j_sum_ff       <= SW'(i_sqx_ff) + SW'(i_sqy_ff) + SW'(i_sqz_ff);
         j_side_ff      <= i_side_ff;
      end
   end

   // ---------------- k = isqrt(|D'|^2) ----------------
   logic [TW-1:0]          s2_k;
   logic [S2W-1:0]         s2_side_bits;
   tnsp_pkg::sq2_side_type s2_side;

   tnsp_isqrt #(
      .ROOT_W (TW),
      .SIDE_W (S2W)
   ) u_sqrt_d (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (j_vld_ff),
      .in_val   (j_sum_ff),
      .in_side  (j_side_ff),
      .out_vld  (s2_vld),
      .out_root (s2_k),
      .out_side (s2_side_bits)
   );

   assign s2_side = tnsp_pkg::sq2_side_type'(s2_side_bits);

   // ---------------- direction select, times r, add rounding half ----------------
   logic [CW-1:0]          nx, ny, nz;
   logic [2:0]             nsgn;
   logic [TW-1:0]          kk;
   logic [NW-1:0]          k_prodx_ff, k_prody_ff, k_prodz_ff;
   logic [TW-1:0]          k_den_ff, m_den_ff;
   tnsp_pkg::dv2_side_type k_side_ff, m_side_ff;
   logic [2:0][NW-1:0]     m_num_ff;

   // on the centre circle fall back to the outward radial direction, or to +x when m is zero
   always_comb begin
      if (s2_k != '0) begin
         nx   = {1'b0, s2_side.ex};
         ny   = {1'b0, s2_side.ey};
         nz   = {1'b0, s2_side.ez};
         nsgn = s2_side.esgn;
         kk   = s2_k;
      end else if (s2_side.m == '0) begin
         nx   = CW'(1);
         ny   = '0;
         nz   = '0;
         nsgn = 3'b000;
         kk   = TW'(1);
      end else begin
         nx   = s2_side.qx[CW-1] ? (~s2_side.qx + 1'b1) : s2_side.qx;
         ny   = s2_side.qy[CW-1] ? (~s2_side.qy + 1'b1) : s2_side.qy;
         nz   = '0;
         nsgn = {1'b0, s2_side.qy[CW-1], s2_side.qx[CW-1]};
         kk   = s2_side.m;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_prodx_ff    <= nx * minor_ff;
         k_prody_ff    <= ny * minor_ff;
         k_prodz_ff    <= nz * minor_ff;
         k_den_ff      <= kk;
         k_side_ff.px  <= s2_side.px;
         k_side_ff.py  <= s2_side.py;
         k_side_ff.sgn <= nsgn;
         m_num_ff[0]   <= k_prodx_ff + NW'(k_den_ff >> 1);
         m_num_ff[1]   <= k_prody_ff + NW'(k_den_ff >> 1);
         m_num_ff[2]   <= k_prodz_ff + NW'(k_den_ff >> 1);
         m_den_ff      <= k_den_ff;
         m_side_ff     <= k_side_ff;
      end
   end

   // ---------------- tube offset: round(|e|*r / k) ----------------
   logic [2:0][NW-1:0]     d2_quot;
   logic [D2W-1:0]         d2_side_bits;
   tnsp_pkg::dv2_side_type d2_side;

   tnsp_div #(
      .LANES  (3),
      .NUM_W  (NW),
      .DEN_W  (TW),
      .SIDE_W (D2W)
   ) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (m_vld_ff),
      .in_den   (m_den_ff),
      .in_num   (m_num_ff),
      .in_side  (m_side_ff),
      .out_vld  (d2_vld),
      .out_quot (d2_quot),
      .out_side (d2_side_bits)
   );

   assign d2_side = tnsp_pkg::dv2_side_type'(d2_side_bits);

   // ---------------- P + offset with saturation ----------------
   logic signed [2:0][63:0]   pbase, offs, tot;
   logic signed [2:0][CW-1:0] near_sel;
   logic signed [CW-1:0]      l_x_ff, l_y_ff, l_z_ff;

   // elements of a packed array read as unsigned, so compare them as signed
   always_comb begin
      pbase[0] = 64'(d2_side.px);
      pbase[1] = 64'(d2_side.py);
      pbase[2] = '0;
      for (int c = 0; c < 3; c++) begin
         offs[c] = d2_side.sgn[c] ? -signed'({2'b00, d2_quot[c]})
                                  : signed'({2'b00, d2_quot[c]});
         tot[c]  = pbase[c] + offs[c];
         if ($signed(tot[c]) > tnsp_pkg::SAT_HI) begin
            near_sel[c] = tnsp_pkg::SAT_HI[CW-1:0];
         end else if ($signed(tot[c]) < tnsp_pkg::SAT_LO) begin
            near_sel[c] = tnsp_pkg::SAT_LO[CW-1:0];
         end else begin
            near_sel[c] = tot[c][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_x_ff <= near_sel[0];
         l_y_ff <= near_sel[1];
         l_z_ff <= near_sel[2];
      end
   end

   // ---------------- output register ----------------
   logic                 rsp_valid_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= l_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_x_ff <= l_x_ff;
         rsp_y_ff <= l_y_ff;
         rsp_z_ff <= l_z_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_near_x = rsp_x_ff;
   assign rsp_near_y = rsp_y_ff;
   assign rsp_near_z = rsp_z_ff;

endmodule

// ===== dv/tb_torus_nearest_surface_point_core.sv =====
// Testbench for the torus nearest-point core: directed table plus random queries.
module tb_torus_nearest_surface_point_core;

   localparam int FRAC = 16;
   localparam int LATENCY = 202;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint LIM31 = 64'sd2147483648;
   // index that maps to no register
   localparam logic [tnsp_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct {
      point_type q;
      logic      check_fixed;
      point_type fixed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_query_x = '0, req_query_y = '0, req_query_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_near_x, rsp_near_y, rsp_near_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tnsp_pkg::CSR_IDX_W-1:0] csr_index = tnsp_pkg::CSR_MAJOR;
   logic [tnsp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   torus_nearest_surface_point_core #(.FRAC_BITS(FRAC)) dut (.*);

   always #10 clock = ~clock;

   // predictor copy of the radii
   longint major_r, minor_r;
   point_type near_queue[$];
   int errors = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   bit stall_mode = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magn(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   function automatic longint round_div(longint n, longint unsigned d);
      longint unsigned q;
      q = (magn(n) + d / 2) / d;
      return n < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > LIM31 - 1) v = LIM31 - 1;
      if (v < -LIM31) v = -LIM31;
      return v[31:0];
   endfunction

   // nearest torus surface point for one query
   function automatic point_type nearest_point(point_type q);
      longint qv[3], pv[3], dv[3], ev[3];
      longint unsigned n2, m, big, sum, k;
      int s;
      point_type r;
      qv[0] = q.x; qv[1] = q.y; qv[2] = q.z;
      n2 = longint'(qv[0] * qv[0]) + longint'(qv[1] * qv[1]);
      m = int_sqrt(n2);
      if (n2 == 0) begin
         pv[0] = major_r; pv[1] = 0;
      end else begin
         pv[0] = round_div(qv[0] * major_r, m);
         pv[1] = round_div(qv[1] * major_r, m);
      end
      pv[2] = 0;
      big = 0;
      for (int i = 0; i < 3; i++) begin
         dv[i] = qv[i] - pv[i];
         if (magn(dv[i]) > big) big = magn(dv[i]);
      end
      s = 0;
      while ((big >> s) >= 64'd2147483648) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         ev[i] = dv[i] < 0 ? -longint'(magn(dv[i]) >> s) : longint'(magn(dv[i]) >> s);
         sum += ev[i] * ev[i];
      end
      k = int_sqrt(sum);
      // on the centre circle: outward radial direction, +x when also on the axis
      if (k == 0) begin
         if (n2 == 0) begin
            ev[0] = 1; ev[1] = 0; k = 1;
         end else begin
            ev[0] = qv[0]; ev[1] = qv[1]; k = m;
         end
         ev[2] = 0;
      end
      r.x = clamp32(pv[0] + round_div(ev[0] * minor_r, k));
      r.y = clamp32(pv[1] + round_div(ev[1] * minor_r, k));
      r.z = clamp32(pv[2] + round_div(ev[2] * minor_r, k));
      return r;
   endfunction

   // receiver stall pattern, switches between busy and calm stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (near_queue.size() == 0) begin
            $display("%0t: unexpected result %0d %0d %0d", $time,
                     rsp_near_x, rsp_near_y, rsp_near_z);
            errors++;
         end else begin
            point_type e;
            e = near_queue.pop_front();
            n_checked++;
            if (e.x !== rsp_near_x) begin
               $display("%0t: near_x expected %0d actual %0d", $time, e.x, rsp_near_x);
               errors++;
            end
            if (e.y !== rsp_near_y) begin
               $display("%0t: near_y expected %0d actual %0d", $time, e.y, rsp_near_y);
               errors++;
            end
            if (e.z !== rsp_near_z) begin
               $display("%0t: near_z expected %0d actual %0d", $time, e.z, rsp_near_z);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", near_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_radius(logic [tnsp_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tnsp_pkg::CSR_MAJOR) major_r = value & 32'h3FFF_FFFF;
      else if (idx == tnsp_pkg::CSR_MINOR) minor_r = value & 32'h3FFF_FFFF;
      @(posedge clock);
   endtask

   // wait for the pipeline to drain before touching the radii
   task automatic drain();
      while (near_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic send_query(point_type q);
      req_valid <= 1'b1;
      req_query_x <= q.x;
      req_query_y <= q.y;
      req_query_z <= q.z;
      do @(posedge clock); while (req_stall);
      near_queue.push_back(nearest_point(q));
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_coord(longint rad);
      unique case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'sh8000_0000 + $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 4 * (rad + 65536)))
                             - 2 * (rad + 65536));
      endcase
   endfunction

   // radii settings walked by the run, extremes included
   logic [31:0] major_set[6] = '{32'd65536, 32'd0, 32'h3FFF_FFFF, 32'd200000, 32'hFFFF_FFFF,
                                 32'd1000};
   logic [31:0] minor_set[6] = '{32'd16384, 32'h3FFF_FFFF, 32'd0, 32'd50000, 32'd7,
                                 32'hC000_1234};

   stim_row_type directed[$];

   initial begin
      point_type q;
      longint cr;
      major_r = 64'd1 << FRAC;
      minor_r = 64'd1 << (FRAC - 2);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset radii (R=1.0, r=0.25)
      directed.push_back('{'{0, 0, 0}, 1, '{49152, 0, 0}});          // on axis
      directed.push_back('{'{65536, 0, 0}, 1, '{81920, 0, 0}});      // on centre circle
      directed.push_back('{'{0, -65536, 0}, 1, '{0, -81920, 0}});
      directed.push_back('{'{131072, 0, 0}, 1, '{81920, 0, 0}});
      directed.push_back('{'{65536, 0, 65536}, 1, '{65536, 0, 16384}});
      directed.push_back('{'{0, 0, 32'sh7FFF_FFFF}, 0, '{0, 0, 0}});
      directed.push_back('{'{0, 0, 32'sh8000_0000}, 0, '{0, 0, 0}});
      directed.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 0, '{0, 0, 0}});
      directed.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, '{0, 0, 0}});
      directed.push_back('{'{32'sh8000_0000, 32'sh7FFF_FFFF, 0}, 0, '{0, 0, 0}});
      directed.push_back('{'{46341, 46341, 0}, 0, '{0, 0, 0}});
      directed.push_back('{'{-1, 1, -1}, 0, '{0, 0, 0}});
      directed.push_back('{'{-32768, 0, 5}, 0, '{0, 0, 0}});
      foreach (directed[i]) begin
         send_query(directed[i].q);
         if (directed[i].check_fixed &&
             (near_queue[$].x !== directed[i].fixed.x ||
              near_queue[$].y !== directed[i].fixed.y ||
              near_queue[$].z !== directed[i].fixed.z)) begin
            $display("%0t: table row %0d expected %0d %0d %0d actual %0d %0d %0d", $time, i,
                     directed[i].fixed.x, directed[i].fixed.y, directed[i].fixed.z,
                     near_queue[$].x, near_queue[$].y, near_queue[$].z);
            errors++;
         end
      end
      req_valid <= 1'b0;

      // random phases across radii settings
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_radius(tnsp_pkg::CSR_MAJOR, major_set[ph]);
         write_radius(tnsp_pkg::CSR_MINOR, minor_set[ph]);
         write_radius(CSR_SPARE, $urandom);                  // unused index, ignored
         cr = major_r;
         for (int n = 0; n < 320; n++) begin
            q.x = rand_coord(cr);
            q.y = rand_coord(cr);
            q.z = rand_coord(cr);
            if ($urandom_range(0, 15) == 0) begin              // on axis
               q.x = 0; q.y = 0;
            end else if ($urandom_range(0, 15) == 0 && cr < 64'sh7FFF_FFFF) begin
               q.x = $urandom_range(0, 1) ? 32'(cr) : 32'(-cr);  // on centre circle
               q.y = 0; q.z = 0;
            end
            send_query(q);
            idle_gap();
         end
         req_valid <= 1'b0;
      end

      while (near_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d results over %0d radius settings plus a directed table",
               n_checked, 6);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
